// ===== rtl/hsfd_pkg.sv =====
package hsfd_pkg;

  // Field and register widths.
  localparam int ByteW  = 8;
  localparam int ThrW   = 14;
  localparam int LimW   = 4;
  localparam int RhW    = 14;
  localparam int TempW  = 15;
  localparam int BarW   = 7;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;
  localparam int MsgW   = 48;

  // Register reset values and tracker constants.
  localparam logic [ThrW-1:0] ThrReset      = 14'd1500;
  localparam logic [LimW-1:0] LimReset      = 4'd3;
  localparam logic [RhW-1:0]  BaselineEmpty = '1;

  // Status byte bits.
  localparam int BusyBit = 7;
  localparam int CalBit  = 3;

  // Scale factors: humidity 0..99.99 %, temperature -50.00..+149.99 C.
  localparam logic [13:0]     RhScale    = 14'd10000;
  localparam logic [14:0]     TempScale  = 15'd20000;
  localparam logic [TempW-1:0] TempOffset = 15'd5000;
  localparam logic [6:0]      BarScale   = 7'd100;
  localparam logic [BarW-1:0] BarMax     = 7'd100;

  // CRC-8 definition.
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_RISE_THRESHOLD = 1'b0,
    REG_ERROR_LIMIT    = 1'b1
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_UNCAL    = 3'd2,
    ST_NOANSWER = 3'd3,
    ST_LOST     = 3'd4
  } status_t;

  // Decoded frame, handed from the decoder to the tracker.
  typedef struct packed {
    logic              answered;
    logic              crc_ok;
    logic              busy;
    logic              uncal;
    logic [RhW-1:0]    rh;
    logic [TempW-1:0]  temp;
    logic [BarW-1:0]   bar;
  } frame_info_t;

  // Bit-serial CRC over a 48-bit message, MSB first. Used only to build
  // constants at elaboration.
  function automatic logic [7:0] crc8_bits(logic [7:0] init, logic [MsgW-1:0] msg);
    logic [7:0] crc;
    logic       fb;
    crc = init;
    for (int j = MsgW - 1; j >= 0; j--) begin
      fb  = crc[7] ^ msg[j];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  // Contribution of each message bit to the CRC; the CRC is linear, so the
  // result is the initial-value term xored with the columns of the set bits.
  function automatic logic [MsgW-1:0][7:0] crc8_columns();
    logic [MsgW-1:0][7:0] cols;
    for (int k = 0; k < MsgW; k++) begin
      cols[k] = crc8_bits(8'h00, MsgW'(1) << k);
    end
    return cols;
  endfunction

endpackage

// ===== rtl/humidity_sensor_frame_decoder.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    answered, status_byte, data_byte_one..five, check_byte
// output    out_valid / out_ready  read_status, humidity_centi, temperature_centi,
//                                  checksum_ok, part_identified, breath_detected, bar_level
// config    APB psel/penable       paddr, pwdata, prdata, pready
//
// An accepted item is held in the input register, which feeds the CRC, scaling and
// tracking logic; its result is loaded into the result register once that register
// is free, and leaves from there on the output channel.
// One item is accepted every cycle while the output side takes results.
// Reset (rst, synchronous) empties both registers, clears the session state and
// loads the register defaults. A stalled result holds the pipe; the input register
// still takes an item while the result register waits, if it is empty.
module humidity_sensor_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsfd_pkg::AddrW-1:0]        paddr,
  input  logic [hsfd_pkg::DataW-1:0]        pwdata,
  output logic [hsfd_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              answered,
  input  logic [hsfd_pkg::ByteW-1:0]        status_byte,
  input  logic [hsfd_pkg::ByteW-1:0]        data_byte_one,
  input  logic [hsfd_pkg::ByteW-1:0]        data_byte_two,
  input  logic [hsfd_pkg::ByteW-1:0]        data_byte_three,
  input  logic [hsfd_pkg::ByteW-1:0]        data_byte_four,
  input  logic [hsfd_pkg::ByteW-1:0]        data_byte_five,
  input  logic [hsfd_pkg::ByteW-1:0]        check_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        read_status,
  output logic [hsfd_pkg::RhW-1:0]          humidity_centi,
  output logic signed [hsfd_pkg::TempW-1:0] temperature_centi,
  output logic                              checksum_ok,
  output logic                              part_identified,
  output logic                              breath_detected,
  output logic [hsfd_pkg::BarW-1:0]         bar_level
);
  import hsfd_pkg::*;

  logic [ThrW-1:0]  rise_threshold;
  logic [LimW-1:0]  error_limit;

  // Input register.
  logic             in_full;
  logic             in_answered;
  logic [ByteW-1:0] in_b0, in_b1, in_b2, in_b3, in_b4, in_b5, in_b6;
  logic             load_ready;
  frame_info_t      info;

  // Configuration registers.
  hsfd_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rise_threshold (rise_threshold),
    .error_limit    (error_limit)
  );

  // The input register frees up whenever its item moves on.
  assign in_ready = !in_full || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_answered <= answered;
      in_b0       <= status_byte;
      in_b1       <= data_byte_one;
      in_b2       <= data_byte_two;
      in_b3       <= data_byte_three;
      in_b4       <= data_byte_four;
      in_b5       <= data_byte_five;
      in_b6       <= check_byte;
    end
  end

  // Frame check and scaling.
  hsfd_frame u_frame (
    .answered        (in_answered),
    .status_byte     (in_b0),
    .data_byte_one   (in_b1),
    .data_byte_two   (in_b2),
    .data_byte_three (in_b3),
    .data_byte_four  (in_b4),
    .data_byte_five  (in_b5),
    .check_byte      (in_b6),
    .info            (info)
  );

  // Session tracking and result register.
  hsfd_track u_track (
    .clk               (clk),
    .rst               (rst),
    .load_valid        (in_full),
    .load_ready        (load_ready),
    .info              (info),
    .rise_threshold    (rise_threshold),
    .error_limit       (error_limit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .read_status       (read_status),
    .humidity_centi    (humidity_centi),
    .temperature_centi (temperature_centi),
    .checksum_ok       (checksum_ok),
    .part_identified   (part_identified),
    .breath_detected   (breath_detected),
    .bar_level         (bar_level)
  );

endmodule

// ===== rtl/hsfd_regs.sv =====
module hsfd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsfd_pkg::AddrW-1:0]    paddr,
  input  logic [hsfd_pkg::DataW-1:0]    pwdata,
  output logic [hsfd_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output logic [hsfd_pkg::ThrW-1:0]     rise_threshold,
  output logic [hsfd_pkg::LimW-1:0]     error_limit
);
  import hsfd_pkg::*;

  logic     wr_en;
  logic     addr_hit;
  cfg_reg_t reg_sel;

  // Registers sit on word boundaries; the word index picks the register.
  assign pready   = 1'b1;
  assign addr_hit = (paddr[1:0] == 2'b00);
  assign reg_sel  = cfg_reg_t'(paddr[2]);
  assign wr_en    = psel && penable && pwrite && addr_hit;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold <= ThrReset;
      error_limit    <= LimReset;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RISE_THRESHOLD: rise_threshold <= pwdata[ThrW-1:0];
        REG_ERROR_LIMIT:    error_limit    <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      case (reg_sel)
        REG_RISE_THRESHOLD: prdata = DataW'(rise_threshold);
        REG_ERROR_LIMIT:    prdata = DataW'(error_limit);
        default:            prdata = '0;
      endcase
    end
  end

endmodule

// ===== rtl/hsfd_frame.sv =====
module hsfd_frame (
  input  logic                        answered,
  input  logic [hsfd_pkg::ByteW-1:0]  status_byte,
  input  logic [hsfd_pkg::ByteW-1:0]  data_byte_one,
  input  logic [hsfd_pkg::ByteW-1:0]  data_byte_two,
  input  logic [hsfd_pkg::ByteW-1:0]  data_byte_three,
  input  logic [hsfd_pkg::ByteW-1:0]  data_byte_four,
  input  logic [hsfd_pkg::ByteW-1:0]  data_byte_five,
  input  logic [hsfd_pkg::ByteW-1:0]  check_byte,
  output hsfd_pkg::frame_info_t       info
);
  import hsfd_pkg::*;

  localparam logic [MsgW-1:0][7:0] CrcCols = crc8_columns();
  localparam logic [7:0]           CrcBase = crc8_bits(CrcInit, '0);

  logic [MsgW-1:0] msg;
  logic [7:0]      crc;
  logic [15:0]     rh16;
  logic [15:0]     t16;
  logic [29:0]     rh_prod;
  logic [30:0]     t_prod;
  logic [22:0]     bar_prod;
  logic [TempW-1:0] t_off;

  assign msg = {status_byte, data_byte_one, data_byte_two,
                data_byte_three, data_byte_four, data_byte_five};

  // CRC as an xor of per-bit columns over the six frame bytes.
  always_comb begin
    crc = CrcBase;
    for (int k = 0; k < MsgW; k++) begin
      if (msg[k]) begin
        crc = crc ^ CrcCols[k];
      end
    end
  end

  // Top 16 bits of the 20-bit raw readings.
  assign rh16 = {data_byte_one, data_byte_two};
  assign t16  = {data_byte_three[3:0], data_byte_four, data_byte_five[7:4]};

  // Scaling to hundredths. The bar comes straight from the raw value, which
  // gives the same floor as dividing the scaled humidity by 100.
  assign rh_prod  = {14'd0, rh16} * {16'd0, RhScale};
  assign t_prod   = {15'd0, t16} * {16'd0, TempScale};
  assign bar_prod = {7'd0, rh16} * {16'd0, BarScale};
  assign t_off    = t_prod[30:16];

  always_comb begin
    info.answered = answered;
    info.crc_ok   = (crc == check_byte);
    info.busy     = status_byte[BusyBit];
    info.uncal    = !status_byte[CalBit];
    info.rh       = rh_prod[29:16];
    info.temp     = t_off - TempOffset;
    info.bar      = (bar_prod[22:16] > BarMax) ? BarMax : bar_prod[22:16];
  end

endmodule

// ===== rtl/hsfd_track.sv =====
module hsfd_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_valid,
  output logic                          load_ready,
  input  hsfd_pkg::frame_info_t         info,
  input  logic [hsfd_pkg::ThrW-1:0]     rise_threshold,
  input  logic [hsfd_pkg::LimW-1:0]     error_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    read_status,
  output logic [hsfd_pkg::RhW-1:0]      humidity_centi,
  output logic signed [hsfd_pkg::TempW-1:0] temperature_centi,
  output logic                          checksum_ok,
  output logic                          part_identified,
  output logic                          breath_detected,
  output logic [hsfd_pkg::BarW-1:0]     bar_level
);
  import hsfd_pkg::*;

  // Session state.
  logic [RhW-1:0]   humidity_baseline, humidity_baseline_next;
  logic [LimW-1:0]  miss_count, miss_count_next;
  logic             identified_latch, identified_latch_next;

  // Result values for the item being loaded.
  status_t          status_next;
  logic [RhW-1:0]   rh_next;
  logic [TempW-1:0] temp_next;
  logic             crc_ok_next;
  logic             breath_next;
  logic [BarW-1:0]  bar_next;
  logic [LimW-1:0]  miss_inc;
  logic [RhW-1:0]   base_min;
  logic             load;

  assign load_ready = !out_valid || out_ready;
  assign load       = load_valid && load_ready;
  assign miss_inc   = miss_count + 4'd1;
  assign base_min   = (info.rh < humidity_baseline) ? info.rh : humidity_baseline;

  // Status decision and state update for one item.
  always_comb begin
    humidity_baseline_next = humidity_baseline;
    miss_count_next        = miss_count;
    identified_latch_next  = identified_latch;
    status_next            = ST_OK;
    rh_next                = '0;
    temp_next              = '0;
    crc_ok_next            = 1'b0;
    breath_next            = 1'b0;
    bar_next               = '0;
    if (!info.answered) begin
      if (miss_inc >= error_limit) begin
        status_next            = ST_LOST;
        humidity_baseline_next = BaselineEmpty;
        identified_latch_next  = 1'b0;
        miss_count_next        = '0;
      end else begin
        status_next     = ST_NOANSWER;
        miss_count_next = miss_inc;
      end
    end else begin
      miss_count_next = '0;
      crc_ok_next     = info.crc_ok;
      if (info.crc_ok) begin
        identified_latch_next = 1'b1;
      end
      if (info.busy) begin
        status_next = ST_BUSY;
      end else if (info.uncal) begin
        status_next = ST_UNCAL;
      end else begin
        humidity_baseline_next = base_min;
        rh_next                = info.rh;
        temp_next              = info.temp;
        bar_next               = info.bar;
        breath_next            = ((info.rh - base_min) >= rise_threshold);
      end
    end
  end

  // State and valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      humidity_baseline <= BaselineEmpty;
      miss_count        <= '0;
      identified_latch  <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (load) begin
        humidity_baseline <= humidity_baseline_next;
        miss_count        <= miss_count_next;
        identified_latch  <= identified_latch_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      read_status       <= status_next;
      humidity_centi    <= rh_next;
      temperature_centi <= temp_next;
      checksum_ok       <= crc_ok_next;
      part_identified   <= identified_latch_next;
      breath_detected   <= breath_next;
      bar_level         <= bar_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import hsfd_pkg::*;

  localparam logic [7:0] SENSOR_POLY = 8'h31;
  localparam logic [7:0] SENSOR_SEED = 8'hFF;
  localparam int         STALL_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 8;

  // One sensor read as it sits on the input channel.
  typedef struct packed {
    logic       answered;
    logic [7:0] status_byte;
    logic [7:0] data_byte_one;
    logic [7:0] data_byte_two;
    logic [7:0] data_byte_three;
    logic [7:0] data_byte_four;
    logic [7:0] data_byte_five;
    logic [7:0] check_byte;
  } sensor_read_t;

  // One decoded reading as it leaves the output channel.
  typedef struct packed {
    status_t     status;
    logic [13:0] humidity;
    logic [14:0] temperature;
    logic        crc_ok;
    logic        identified;
    logic        breath;
    logic [6:0]  bar;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        answered = 1'b0;
  logic [7:0]  status_byte = '0;
  logic [7:0]  data_byte_one = '0;
  logic [7:0]  data_byte_two = '0;
  logic [7:0]  data_byte_three = '0;
  logic [7:0]  data_byte_four = '0;
  logic [7:0]  data_byte_five = '0;
  logic [7:0]  check_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  read_status;
  logic [13:0] humidity_centi;
  logic signed [14:0] temperature_centi;
  logic        checksum_ok;
  logic        part_identified;
  logic        breath_detected;
  logic [6:0]  bar_level;

  humidity_sensor_frame_decoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .answered(answered), .status_byte(status_byte),
    .data_byte_one(data_byte_one), .data_byte_two(data_byte_two),
    .data_byte_three(data_byte_three), .data_byte_four(data_byte_four),
    .data_byte_five(data_byte_five), .check_byte(check_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_status(read_status), .humidity_centi(humidity_centi),
    .temperature_centi(temperature_centi), .checksum_ok(checksum_ok),
    .part_identified(part_identified), .breath_detected(breath_detected),
    .bar_level(bar_level)
  );

  always #1 clk = ~clk;

  // Predictor state and its copy of the registers, at reset values.
  logic [13:0] rise_thr = 14'd1500;
  logic [3:0]  miss_lim = 4'd3;
  logic [13:0] base_rh = '1;
  logic [3:0]  miss_cnt = '0;
  logic        id_latch = 1'b0;

  sensor_read_t reads_to_send[$];
  decode_t      predicted_decodes[$];
  sensor_read_t next_read;
  decode_t      want;
  int           mismatches = 0;
  int           idle_cycles = 0;

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch on %s: got %0d, predicted %0d", what, got, exp_val);
    mismatches++;
  endtask

  // CRC-8 over the status byte and the five data bytes, MSB first.
  function automatic logic [7:0] frame_crc(sensor_read_t r);
    logic [47:0] msg;
    logic [7:0]  c;
    msg = {r.status_byte, r.data_byte_one, r.data_byte_two, r.data_byte_three,
           r.data_byte_four, r.data_byte_five};
    c = SENSOR_SEED;
    for (int i = 47; i >= 0; i--) begin
      c = {c[6:0], 1'b0} ^ ((c[7] ^ msg[i]) ? SENSOR_POLY : 8'h00);
    end
    return c;
  endfunction

  // Works out the decoded reading for one accepted item and advances the
  // session state: miss counting, the identified latch and the baseline.
  function automatic decode_t decode_reading(sensor_read_t r);
    decode_t     res;
    logic [15:0] rh16;
    logic [15:0] t16;
    logic [31:0] prod;
    logic [14:0] t_off;
    int          bar;
    res = '0;
    res.status = ST_OK;
    if (!r.answered) begin
      miss_cnt = miss_cnt + 4'd1;
      if (miss_cnt >= miss_lim) begin
        res.status = ST_LOST;
        base_rh = '1;
        id_latch = 1'b0;
        miss_cnt = '0;
      end else begin
        res.status = ST_NOANSWER;
      end
    end else begin
      miss_cnt = '0;
      res.crc_ok = (frame_crc(r) == r.check_byte);
      if (res.crc_ok) id_latch = 1'b1;
      if (r.status_byte[7]) begin
        res.status = ST_BUSY;
      end else if (!r.status_byte[3]) begin
        res.status = ST_UNCAL;
      end else begin
        rh16 = {r.data_byte_one, r.data_byte_two};
        t16 = {r.data_byte_three[3:0], r.data_byte_four, r.data_byte_five[7:4]};
        prod = rh16 * 32'd10000;
        res.humidity = prod[29:16];
        prod = t16 * 32'd20000;
        t_off = prod[30:16];
        res.temperature = t_off - 15'd5000;
        if (res.humidity < base_rh) base_rh = res.humidity;
        res.breath = (res.humidity - base_rh) >= rise_thr;
        bar = res.humidity / 100;
        res.bar = (bar > 100) ? 7'd100 : bar[6:0];
      end
    end
    res.identified = id_latch;
    return res;
  endfunction

  // Builds an answered frame; spoil is xored into the correct check byte.
  function automatic sensor_read_t frame_of(logic [7:0] st, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                            logic [7:0] spoil);
    sensor_read_t r;
    r = {1'b1, st, b1, b2, b3, b4, b5, 8'h00};
    r.check_byte = frame_crc(r) ^ spoil;
    return r;
  endfunction

  // A read that got no answer; the bytes carry random noise.
  function automatic sensor_read_t silent_read();
    sensor_read_t r;
    r = {1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 8'($urandom), 8'($urandom)};
    return r;
  endfunction

  // Random frame, mostly well formed, with humidity near a phase level
  // half of the time so the baseline and threshold logic both toggle.
  function automatic sensor_read_t random_read(int level);
    sensor_read_t r;
    logic [7:0]   st;
    int           dice;
    int           h;
    dice = $urandom_range(0, 99);
    st = 8'($urandom);
    if (dice < 75) begin
      st[7] = 1'b0;
      st[3] = 1'b1;
    end else if (dice < 88) begin
      st[7] = 1'b1;
    end else begin
      st[7] = 1'b0;
      st[3] = 1'b0;
    end
    if ($urandom_range(0, 1) == 0) begin
      h = $urandom_range(0, 65535);
    end else begin
      h = level + $urandom_range(0, 24000) - 4000;
      if (h < 0) h = 0;
      if (h > 65535) h = 65535;
    end
    r = frame_of(st, h[15:8], h[7:0], 8'($urandom), 8'($urandom), 8'($urandom),
                 ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)));
    return r;
  endfunction

  // Writes a register, then reads it back over the same port.
  task automatic write_setting(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_RISE_THRESHOLD) rise_thr = val[13:0];
    else miss_lim = val[3:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) report_mismatch("register readback", prdata, val);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the stimulus until every queued read and prediction is used up.
  task automatic drain();
    while (reads_to_send.size() != 0 || in_valid || predicted_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Sender: bursts of items with random gaps, prediction on acceptance.
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        next_read = {answered, status_byte, data_byte_one, data_byte_two, data_byte_three,
                     data_byte_four, data_byte_five, check_byte};
        predicted_decodes.push_back(decode_reading(next_read));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (reads_to_send.size() > 0) begin
          next_read = reads_to_send.pop_front();
          answered <= next_read.answered;
          status_byte <= next_read.status_byte;
          data_byte_one <= next_read.data_byte_one;
          data_byte_two <= next_read.data_byte_two;
          data_byte_three <= next_read.data_byte_three;
          data_byte_four <= next_read.data_byte_four;
          data_byte_five <= next_read.data_byte_five;
          check_byte <= next_read.check_byte;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(20, 40);
            else if ($urandom_range(0, 2) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between always ready, coin flips, a fixed one-in-four
  // pattern and long stalls.
  int rx_mode = 0;
  int rx_mode_left = 40;
  int rx_stall_left = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (rx_cycle % 4 == 0);
      end
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left <= rx_stall_left - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          rx_stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : 0;
        end
      end
    endcase
  end

  // Checks each result against the oldest prediction, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_decodes.size() == 0) begin
        report_mismatch("unexpected result, read_status", read_status, -1);
      end else begin
        want = predicted_decodes.pop_front();
        if (read_status !== want.status)
          report_mismatch("read_status", read_status, want.status);
        if (humidity_centi !== want.humidity)
          report_mismatch("humidity_centi", humidity_centi, want.humidity);
        if (temperature_centi !== want.temperature)
          report_mismatch("temperature_centi", temperature_centi,
                          $signed(want.temperature));
        if (checksum_ok !== want.crc_ok)
          report_mismatch("checksum_ok", checksum_ok, want.crc_ok);
        if (part_identified !== want.identified)
          report_mismatch("part_identified", part_identified, want.identified);
        if (breath_detected !== want.breath)
          report_mismatch("breath_detected", breath_detected, want.breath);
        if (bar_level !== want.bar)
          report_mismatch("bar_level", bar_level, want.bar);
      end
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed items at reset settings, then random phases.
  int thr_plan[5] = '{0, 10000, 16383, 1, 9999};
  int lim_plan[5] = '{1, 15, 0, 2, 4};
  initial begin
    int level;
    int thr;
    int lim;
    int run;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Three misses in a row reach the default limit and lose the session.
    repeat (3) reads_to_send.push_back(silent_read());
    // Extremes of humidity and temperature on good frames.
    reads_to_send.push_back(frame_of(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reads_to_send.push_back(frame_of(8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    // Busy, uncalibrated, and both at once, where busy wins.
    reads_to_send.push_back(frame_of(8'h80, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h00));
    reads_to_send.push_back(frame_of(8'h88, 8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h23, 8'h5A));
    reads_to_send.push_back(frame_of(8'h00, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h00));
    reads_to_send.push_back(frame_of(8'hF7, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00));
    reads_to_send.push_back(frame_of(8'h77, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00));
    reads_to_send.push_back(frame_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Good status with a bad checksum still decodes.
    reads_to_send.push_back(frame_of(8'h08, 8'h60, 8'h00, 8'h00, 8'h60, 8'h00, 8'h01));
    reads_to_send.push_back(frame_of(8'h1C, 8'h70, 8'h11, 8'h22, 8'h33, 8'h44, 8'h80));
    // An answer in between resets the miss count; then three misses lose it.
    reads_to_send.push_back(silent_read());
    reads_to_send.push_back(frame_of(8'h08, 8'h90, 8'h00, 8'h00, 8'h90, 8'h00, 8'h00));
    repeat (3) reads_to_send.push_back(silent_read());
    // Fresh baseline at exactly 50.00 %, then a rise one short of the
    // threshold and one exactly at it.
    reads_to_send.push_back(frame_of(8'h08, 8'h80, 8'h00, 8'h00, 8'h66, 8'h00, 8'h00));
    reads_to_send.push_back(frame_of(8'h08, 8'hA6, 8'h66, 8'h00, 8'h66, 8'h00, 8'h00));
    reads_to_send.push_back(frame_of(8'h08, 8'hA6, 8'h67, 8'h00, 8'h66, 8'h00, 8'h00));
    // A lower reading moves the baseline down.
    reads_to_send.push_back(frame_of(8'h08, 8'h10, 8'h00, 8'h00, 8'h66, 8'h00, 8'h00));
    reads_to_send.push_back(frame_of(8'h08, 8'h40, 8'h00, 8'h0F, 8'h66, 8'h00, 8'h00));
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p < 5) begin
        thr = thr_plan[p];
        lim = lim_plan[p];
      end else begin
        thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 3000);
        lim = $urandom_range(0, 15);
      end
      write_setting(REG_RISE_THRESHOLD, thr);
      write_setting(REG_ERROR_LIMIT, lim);
      level = $urandom_range(0, 50000);
      for (int n = 0; n < 57; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          run = $urandom_range(1, 16);
          repeat (run) reads_to_send.push_back(silent_read());
        end else if ($urandom_range(0, 15) == 0) begin
          reads_to_send.push_back(silent_read());
        end else begin
          reads_to_send.push_back(random_read(level));
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hsfd_pkg.sv
rtl/hsfd_regs.sv
rtl/hsfd_frame.sv
rtl/hsfd_track.sv
rtl/humidity_sensor_frame_decoder.sv
tb/tb_top.sv
